// ===== design/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants of the counter priority task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

  localparam int MODE_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int PRIO_W  = 8;
  localparam int SLICE_W = 9;
  localparam int DEPTH_W = 8;
  localparam int TASK_W  = 6;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_YIELD   = 3'd1,
    MODE_DISABLE = 3'd2,
    MODE_ENABLE  = 3'd3,
    MODE_SETUP   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFRESH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               present;
    logic               runnable;
    logic [PRIO_W-1:0]  prio;
    logic [SLICE_W-1:0] slice;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/cps_cell.sv =====
// ----------------------------------------------------------------------------
// cps_cell
// One task slot of the rotating slot ring; loads its neighbor on shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cps_cell
  import cps_pkg::*;
#(
  parameter bit IS_HOME = 1'b0
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t nxt_i,
  output entry_t      q_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.present  <= IS_HOME;
      entry_q.runnable <= IS_HOME;
      entry_q.prio     <= PRIO_W'(IS_HOME);
      entry_q.slice    <= '0;
      entry_q.depth    <= '0;
    end else if (shift_i) begin
      entry_q <= nxt_i;
    end
  end

  assign q_o = entry_q;

endmodule

`default_nettype wire

// ===== design/cps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cps_ctrl
// Event sequencer: updates the slot at the ring head, tracks the best
// runnable slot, refreshes slices and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cps_ctrl
  import cps_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [MODE_W-1:0]  mode_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [PRIO_W-1:0]  prio_i,
  input  wire logic               runnable_i,
  input  wire logic               present_i,
  input  wire entry_t             head_i,
  output entry_t                  head_o,
  output logic                    shift_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    switched_o,
  output logic [TASK_W-1:0]       current_task_o,
  output logic [SLICE_W-1:0]      current_slice_o
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

  state_e state_q, state_d;

  logic [MODE_W-1:0]  mode_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [PRIO_W-1:0]  prio_q;
  logic               run_q, pres_q;
  logic [IW-1:0]      step_q, cur_q, best_q;
  logic               any_q, resched_q, sw_q;
  logic [SLICE_W-1:0] top_q, slice0_q, slcur_q, res_slice_q;

  logic               out_valid_q, out_sw_q;
  logic [TASK_W-1:0]  out_task_q;
  logic [SLICE_W-1:0] out_slice_q;

  logic               accept, out_free, last, at_cur, refreshing;
  entry_t             e;
  logic               rnow, cand, any_eff, any_n, resched_n, need_refresh;
  logic [SLICE_W-1:0] top_eff, top_n, slice0_n, slcur_n, new_slice;
  logic [IW-1:0]      best_n, new_cur;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = (step_q == LAST);
  assign at_cur   = (step_q == cur_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:    if (last) state_d = need_refresh ? ST_REFRESH : ST_FINISH;
      ST_REFRESH: if (last) state_d = ST_FINISH;
      ST_FINISH:  if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    shift_o    = 1'b0;
    refreshing = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_stall_o = 1'b0;
      ST_SCAN:    shift_o = 1'b1;
      ST_REFRESH: begin
        shift_o    = 1'b1;
        refreshing = 1'b1;
      end
      ST_FINISH:  in_stall_o = 1'b1;
      default:    in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    e    = head_i;
    rnow = 1'b0;
    if (refreshing) begin
      if (head_i.present) begin
        e.slice = (head_i.slice >> 1) + SLICE_W'(head_i.prio);
      end
    end else begin
      if (at_cur) begin
        case (mode_q)
          MODE_TICK: begin
            if (head_i.slice != '0) e.slice = head_i.slice - SLICE_W'(1);
            rnow = (e.slice == '0) && (head_i.depth == '0);
          end
          MODE_YIELD: begin
            e.slice = '0;
            rnow    = 1'b1;
          end
          MODE_DISABLE: begin
            if (head_i.depth != DEPTH_MAX) e.depth = head_i.depth + DEPTH_W'(1);
          end
          MODE_ENABLE: begin
            if (head_i.depth != '0) e.depth = head_i.depth - DEPTH_W'(1);
          end
          default: rnow = 1'b0;
        endcase
      end
      if (mode_q == MODE_SETUP && XW'(step_q) == XW'(slot_q)) begin
        e.prio     = (prio_q == '0) ? PRIO_W'(1) : prio_q;
        e.slice    = SLICE_W'(e.prio);
        e.runnable = run_q;
        e.present  = pres_q;
        e.depth    = '0;
      end
    end

    any_eff = (step_q == '0) ? 1'b0 : any_q;
    top_eff = (step_q == '0) ? '0 : top_q;
    cand    = e.present && e.runnable && (!any_eff || e.slice > top_eff);
    any_n   = any_eff || (e.present && e.runnable);
    top_n   = cand ? e.slice : top_eff;
    best_n  = cand ? step_q : best_q;

    slice0_n  = (step_q == '0) ? e.slice : slice0_q;
    slcur_n   = at_cur ? e.slice : slcur_q;
    resched_n = resched_q || (at_cur && rnow);

    need_refresh = resched_n && any_n && (top_n == '0);
    new_cur      = cur_q;
    new_slice    = slcur_n;
    if (refreshing) begin
      new_cur   = best_n;
      new_slice = top_n;
    end else if (resched_n) begin
      new_cur   = any_n ? best_n : '0;
      new_slice = any_n ? top_n : slice0_n;
    end
  end

  assign head_o = e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift_o && last && state_d == ST_FINISH) begin
        cur_q <= new_cur;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      slot_q    <= slot_i;
      prio_q    <= prio_i;
      run_q     <= runnable_i;
      pres_q    <= present_i;
      step_q    <= '0;
      resched_q <= 1'b0;
    end
    if (shift_o) begin
      step_q    <= last ? '0 : step_q + IW'(1);
      any_q     <= any_n;
      top_q     <= top_n;
      best_q    <= best_n;
      slice0_q  <= slice0_n;
      slcur_q   <= slcur_n;
      resched_q <= resched_n;
      if (last && state_d == ST_FINISH) begin
        sw_q        <= (new_cur != cur_q);
        res_slice_q <= new_slice;
      end
    end
    if (state_q == ST_FINISH && out_free) begin
      out_sw_q    <= sw_q;
      out_task_q  <= TASK_W'(cur_q);
      out_slice_q <= res_slice_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign switched_o      = out_sw_q;
  assign current_task_o  = out_task_q;
  assign current_slice_o = out_slice_q;

endmodule

`default_nettype wire

// ===== design/counter_priority_task_scheduler.sv =====
// An accepted event runs a scan pass around the ring, plus a slice refresh pass when needed,
// then its result is registered; no new event is taken before that. The ring turns one slot
// per cycle during those passes. A result waits in an output register while the next event
// is taken; an event that finishes while that result is still stalled holds until it leaves.
// Reset (asynchronous, active low): slot 0 present, runnable, priority 1; others free;
// all slices and preemption depths zero; current task 0; no result pending.
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Slot table held in a rotating chain of cells with a sequencer at its head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module counter_priority_task_scheduler
  import cps_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [MODE_W-1:0]  mode_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [PRIO_W-1:0]  prio_i,
  input  wire logic               runnable_i,
  input  wire logic               present_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    switched_o,
  output logic [TASK_W-1:0]       current_task_o,
  output logic [SLICE_W-1:0]      current_slice_o
);

  entry_t cell_q [TASK_SLOTS];
  entry_t head_wr;
  logic   shift;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_ring
    entry_t nxt;
    if (i == TASK_SLOTS - 1) begin : g_tail
      assign nxt = head_wr;
    end else begin : g_mid
      assign nxt = cell_q[i+1];
    end
    cps_cell #(
      .IS_HOME(i == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .nxt_i  (nxt),
      .q_o    (cell_q[i])
    );
  end

  cps_ctrl #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .slot_i         (slot_i),
    .prio_i         (prio_i),
    .runnable_i     (runnable_i),
    .present_i      (present_i),
    .head_i         (cell_q[0]),
    .head_o         (head_wr),
    .shift_o        (shift),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .switched_o     (switched_o),
    .current_task_o (current_task_o),
    .current_slice_o(current_slice_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("event accepted while the ring was busy");

  a_result_from_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an event in progress");

  a_task_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (TASK_SLOTS < 64) |-> 32'(current_task_o) < TASK_SLOTS)
    else $error("current task outside the slot table");
`endif

endmodule

`default_nettype wire

// ===== dv/counter_priority_task_scheduler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_test
// Self-checking bench for the counter priority task scheduler. A queue of
// scheduler events (directed corner cases, then episodes of slot setups
// followed by tick/yield/preemption traffic, bursts and noise) feeds a
// clocked driver. Every accepted event runs through an in-bench scheduler
// model whose expected results are matched in order against the output
// channel, under phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------

module counter_priority_task_scheduler_test;
  import cps_pkg::*;

  localparam int TASK_SLOTS   = 64;
  localparam int RANDOM_ITEMS = 1050;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * TASK_SLOTS + 20;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic              runnable;
    logic              present;
  } sched_event_t;

  typedef struct packed {
    logic               switched;
    logic [TASK_W-1:0]  task_idx;
    logic [SLICE_W-1:0] slice;
  } sched_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [MODE_W-1:0]  mode_i = '0;
  logic [SLOT_W-1:0]  slot_i = '0;
  logic [PRIO_W-1:0]  prio_i = '0;
  logic               runnable_i = 1'b0;
  logic               present_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               switched_o;
  logic [TASK_W-1:0]  current_task_o;
  logic [SLICE_W-1:0] current_slice_o;

  counter_priority_task_scheduler #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .slot_i         (slot_i),
    .prio_i         (prio_i),
    .runnable_i     (runnable_i),
    .present_i      (present_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .switched_o     (switched_o),
    .current_task_o (current_task_o),
    .current_slice_o(current_slice_o)
  );

  // scheduler model state
  logic [SLICE_W-1:0] slice_tbl [TASK_SLOTS];
  logic [PRIO_W-1:0]  prio_tbl  [TASK_SLOTS];
  logic               run_tbl   [TASK_SLOTS];
  logic               pres_tbl  [TASK_SLOTS];
  logic [DEPTH_W-1:0] depth_tbl [TASK_SLOTS];
  logic [TASK_W-1:0]  cur_task;

  sched_event_t  pending_q [$];
  sched_result_t expected_q [$];
  sched_event_t  drive_ev;
  sched_result_t want;

  int total_items = 0;
  int events_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int switch_count = 0;
  int refresh_count = 0;
  int depth_peak = 0;
  int quiet_cycles = 0;

  int send_idle_pct [4] = '{0, 74, 0, 26};
  int recv_stall_pct [4] = '{0, 0, 74, 26};

  function automatic logic pick_task(output logic [TASK_W-1:0] best);
    logic               any;
    logic [SLICE_W-1:0] top;
    any = 1'b0;
    top = '0;
    best = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (pres_tbl[i] && run_tbl[i] && (!any || slice_tbl[i] > top)) begin
        top = slice_tbl[i];
        best = TASK_W'(i);
        any = 1'b1;
      end
    end
    return !any || top != '0;
  endfunction

  function automatic void reschedule_tasks();
    logic [TASK_W-1:0]  next;
    logic [SLICE_W:0]   grown;
    if (!pick_task(next)) begin
      refresh_count++;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (pres_tbl[i]) begin
          grown = {1'b0, slice_tbl[i] >> 1} + prio_tbl[i];
          slice_tbl[i] = (grown > 511) ? '1 : grown[SLICE_W-1:0];
        end
      end
      void'(pick_task(next));
    end
    cur_task = next;
  endfunction

  function automatic sched_result_t predict_event(sched_event_t ev);
    logic [TASK_W-1:0] prev;
    logic [PRIO_W-1:0] p;
    sched_result_t     r;
    prev = cur_task;
    case (ev.mode)
      MODE_TICK: begin
        if (slice_tbl[cur_task] != '0) slice_tbl[cur_task] = slice_tbl[cur_task] - 1'b1;
        if (slice_tbl[cur_task] == '0 && depth_tbl[cur_task] == '0) reschedule_tasks();
      end
      MODE_YIELD: begin
        slice_tbl[cur_task] = '0;
        reschedule_tasks();
      end
      MODE_DISABLE: begin
        if (depth_tbl[cur_task] != DEPTH_MAX) depth_tbl[cur_task] = depth_tbl[cur_task] + 1'b1;
        if (int'(depth_tbl[cur_task]) > depth_peak) depth_peak = int'(depth_tbl[cur_task]);
      end
      MODE_ENABLE: begin
        if (depth_tbl[cur_task] != '0) depth_tbl[cur_task] = depth_tbl[cur_task] - 1'b1;
      end
      MODE_SETUP: begin
        p = (ev.prio == '0) ? PRIO_W'(1) : ev.prio;
        prio_tbl[ev.slot] = p;
        slice_tbl[ev.slot] = SLICE_W'(p);
        run_tbl[ev.slot] = ev.runnable;
        pres_tbl[ev.slot] = ev.present;
        depth_tbl[ev.slot] = '0;
      end
      default: ;
    endcase
    r.switched = (cur_task != prev);
    r.task_idx = cur_task;
    r.slice = slice_tbl[cur_task];
    return r;
  endfunction

  task automatic add_event(input int m, input int s, input int p,
                           input int r, input int pr);
    sched_event_t ev;
    ev.mode = MODE_W'(m);
    ev.slot = SLOT_W'(s);
    ev.prio = PRIO_W'(p);
    ev.runnable = r[0];
    ev.present = pr[0];
    pending_q.push_back(ev);
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= '0;
      slot_i <= '0;
      prio_i <= '0;
      runnable_i <= 1'b0;
      present_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict_event(drive_ev));
        events_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 &&
            $urandom_range(99) >= send_idle_pct[(events_taken * 4 / total_items) % 4]) begin
          drive_ev = pending_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= drive_ev.mode;
          slot_i <= drive_ev.slot;
          prio_i <= drive_ev.prio;
          runnable_i <= drive_ev.runnable;
          present_i <= drive_ev.present;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (switched_o) switch_count++;
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result task %0d slice %0d", $time, current_task_o,
                   current_slice_o);
        end else begin
          want = expected_q.pop_front();
          if (switched_o !== want.switched) begin
            error_count++;
            $display("%0t: switched expected %0d actual %0d", $time, want.switched, switched_o);
          end
          if (current_task_o !== want.task_idx) begin
            error_count++;
            $display("%0t: current_task expected %0d actual %0d", $time, want.task_idx,
                     current_task_o);
          end
          if (current_slice_o !== want.slice) begin
            error_count++;
            $display("%0t: current_slice expected %0d actual %0d", $time, want.slice,
                     current_slice_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) <
                      recv_stall_pct[(results_seen * 4 / total_items) % 4]);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("counter_priority_task_scheduler_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    int n;
    int pick;
    bit burst_done;
    burst_done = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slice_tbl[i] = '0;
      prio_tbl[i] = '0;
      run_tbl[i] = 1'b0;
      pres_tbl[i] = 1'b0;
      depth_tbl[i] = '0;
    end
    prio_tbl[0] = 1;
    run_tbl[0] = 1'b1;
    pres_tbl[0] = 1'b1;
    cur_task = '0;

    // directed corner cases
    add_event(MODE_TICK, 0, 0, 0, 0);
    add_event(MODE_YIELD, 63, 255, 1, 1);
    add_event(MODE_DISABLE, 0, 0, 0, 0);
    add_event(MODE_ENABLE, 0, 0, 0, 0);
    add_event(MODE_ENABLE, 0, 0, 0, 0);
    for (int m = int'(MODE_SETUP) + 1; m < (1 << MODE_W); m++) add_event(m, 63, 255, 1, 1);
    add_event(MODE_SETUP, 63, 255, 1, 1);
    add_event(MODE_SETUP, 1, 0, 1, 1);
    add_event(MODE_SETUP, 2, 1, 0, 1);
    add_event(MODE_SETUP, 3, 5, 1, 0);
    add_event(MODE_YIELD, 0, 0, 0, 0);
    add_event(MODE_DISABLE, 0, 0, 0, 0);
    add_event(MODE_TICK, 0, 0, 0, 0);
    add_event(MODE_YIELD, 0, 0, 0, 0);
    add_event(MODE_TICK, 0, 0, 0, 0);
    add_event(MODE_SETUP, 63, 7, 0, 0);
    add_event(MODE_SETUP, 1, 7, 0, 0);
    add_event(MODE_SETUP, 0, 1, 0, 0);
    add_event(MODE_YIELD, 0, 0, 0, 0);
    add_event(MODE_TICK, 0, 0, 0, 0);
    add_event(MODE_SETUP, 0, 1, 1, 1);

    // random episodes
    n = pending_q.size() + RANDOM_ITEMS;
    while (pending_q.size() < n) begin
      roll = $urandom_range(99);
      if (!burst_done && pending_q.size() > n / 2) begin
        burst_done = 1'b1;
        repeat (258) add_event(MODE_DISABLE, $urandom_range(63), $urandom_range(255),
                               $urandom_range(1), $urandom_range(1));
        add_event(MODE_TICK, 0, 0, 0, 0);
        add_event(MODE_YIELD, 0, 0, 0, 0);
      end else if (roll < 82) begin
        repeat ($urandom_range(1, 4)) begin
          add_event(MODE_SETUP,
                    ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7),
                    ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 6),
                    $urandom_range(9) != 0, $urandom_range(9) != 0);
        end
        repeat ($urandom_range(5, 30)) begin
          pick = $urandom_range(99);
          if (pick < 55) add_event(MODE_TICK, $urandom_range(63), $urandom_range(255),
                                   $urandom_range(1), $urandom_range(1));
          else if (pick < 70) add_event(MODE_YIELD, $urandom_range(63), $urandom_range(255),
                                        $urandom_range(1), $urandom_range(1));
          else if (pick < 80) add_event(MODE_DISABLE, $urandom_range(63), $urandom_range(255),
                                        $urandom_range(1), $urandom_range(1));
          else if (pick < 90) add_event(MODE_ENABLE, $urandom_range(63), $urandom_range(255),
                                        $urandom_range(1), $urandom_range(1));
          else add_event(MODE_SETUP, $urandom_range(7), $urandom_range(1, 6),
                         $urandom_range(1), $urandom_range(1));
        end
      end else begin
        repeat ($urandom_range(1, 8)) add_event($urandom_range(7), $urandom_range(63),
                                                $urandom_range(255), $urandom_range(1),
                                                $urandom_range(1));
      end
    end
    total_items = pending_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (events_taken < total_items || expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d events, %0d results checked, %0d task switches", events_taken,
             results_seen, switch_count);
    $display("slice refreshes %0d, deepest preemption hold %0d", refresh_count, depth_peak);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("counter_priority_task_scheduler_test: clean");
    end else begin
      $display("counter_priority_task_scheduler_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cps_pkg.sv
design/cps_cell.sv
design/cps_ctrl.sv
design/counter_priority_task_scheduler.sv
dv/counter_priority_task_scheduler_test.sv
